// ===== rtl/usb_control_endpoint_requests_defines.svh =====
// assertion macros for the control endpoint request handler
// used by the checker module, no other dependencies
`ifndef USB_CONTROL_ENDPOINT_REQUESTS_DEFINES_SVH
`define USB_CONTROL_ENDPOINT_REQUESTS_DEFINES_SVH

// concurrent check on clk_i, quiet while rst_ni is low
`define UCER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check that also holds while reset is applied
`define UCER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/ucer_pkg.sv =====
// types and codes shared by the control endpoint request handler
// no dependencies
package ucer_pkg;

  // endpoint 0 events
  typedef enum logic [1:0] {
    FUNC_SETUP     = 2'd0,
    FUNC_IN_DONE   = 2'd1,
    FUNC_OUT_DONE  = 2'd2,
    FUNC_BUS_RESET = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEVICE_LEN  = 3'd0,
    CFG_CONFIG_LEN  = 3'd1,
    CFG_REPORT_LEN  = 3'd2,
    CFG_STRING0_LEN = 3'd3,
    CFG_STRING1_LEN = 3'd4,
    CFG_STRING2_LEN = 3'd5,
    CFG_STRING3_LEN = 3'd6,
    CFG_STRING4_LEN = 3'd7
  } cfg_idx_e;

  // endpoint 0 handshake codes
  localparam logic [1:0] HS_ACK    = 2'd0;
  localparam logic [1:0] HS_STALL  = 2'd1;
  localparam logic [1:0] HS_NAK_IN = 2'd2;

  // data sources
  localparam logic [3:0] SRC_NONE         = 4'd0;
  localparam logic [3:0] SRC_DEVICE       = 4'd1;
  localparam logic [3:0] SRC_CONFIG       = 4'd2;
  localparam logic [3:0] SRC_STRING0      = 4'd3;
  localparam logic [3:0] SRC_REPORT       = 4'd8;
  localparam logic [3:0] SRC_ZERO_STATUS  = 4'd9;
  localparam logic [3:0] SRC_CONFIG_VALUE = 4'd10;

  // ep1 actions
  localparam logic [1:0] EP1_NONE  = 2'd0;
  localparam logic [1:0] EP1_CLEAR = 2'd1;
  localparam logic [1:0] EP1_STALL = 2'd2;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;
  localparam logic [7:0] REQ_NONE              = 8'hFF;

  // descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_REPORT = 8'h22;

  // request type fields and the one endpoint that takes feature requests
  localparam logic [4:0] RECIP_ENDPOINT = 5'd2;
  localparam logic [7:0] EP1_IN_ADDR    = 8'h81;
  localparam logic [7:0] MAX_STRING_IDX = 8'd4;

  // input item
  typedef struct packed {
    func_e       func;
    logic        packet_ok;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
  } ucer_in_t;

  // result item
  typedef struct packed {
    logic [1:0] handshake;
    logic [6:0] tx_length;
    logic [3:0] data_source;
    logic [7:0] data_offset;
    logic       data_toggle;
    logic [6:0] device_address;
    logic [1:0] ep1_action;
    logic [7:0] active_configuration;
  } ucer_out_t;

  // descriptor lengths from the configuration registers
  typedef struct packed {
    logic [7:0]      device_len;
    logic [7:0]      config_len;
    logic [7:0]      report_len;
    logic [4:0][7:0] string_len;
  } ucer_lens_t;

  localparam ucer_lens_t LENS_RESET = '{
    device_len: 8'd18,
    config_len: 8'd34,
    report_len: 8'd51,
    string_len: {8'd2, 8'd2, 8'd2, 8'd2, 8'd4}
  };

endpackage

// ===== rtl/usb_control_endpoint_requests.sv =====
// USB control endpoint (EP0) standard request handler, top level.
// Depends on ucer_pkg, ucer_stage, ucer_cfg_regs and ucer_engine.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one EP0
// event per transfer: setup packet, IN done, OUT done or bus reset.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns one
// result per event: handshake, next IN chunk (length, source, offset,
// toggle), address in effect, EP1 action and active configuration.
// Configuration port (cfg_valid_i / cfg_ready_o) writes the descriptor
// lengths; it is always ready. It is to be written by the user only while
// no event is in flight; the block itself does not enforce this.
//
// Each event passes through one input register, then the decode logic and
// the result register. One event is taken every cycle unless out_stall_i
// holds the result; the endpoint state updates as the event moves into the
// result register. When out_stall_i holds the result, one more event waits
// in the input register before in_stall_o rises.
// Reset clears both stages and loads the default descriptor lengths.
module usb_control_endpoint_requests
  import ucer_pkg::*;
#(
  parameter int unsigned EP0_PACKET_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ucer_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ucer_out_t out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic       a_valid, b_stall, fire;
  ucer_in_t   a_item;
  ucer_lens_t lens;
  ucer_out_t  result;

  assign cfg_ready_o = 1'b1;

  // input register
  ucer_stage #(
    .Width ($bits(ucer_in_t))
  ) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (a_valid),
    .out_stall_i (b_stall),
    .out_data_o  (a_item)
  );

  // descriptor length registers
  ucer_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .lens_o      (lens)
  );

  // event moves on when the result register can take it
  assign fire = a_valid && !b_stall;

  ucer_engine #(
    .Ep0PacketBytes (EP0_PACKET_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (a_item),
    .lens_i   (lens),
    .result_o (result)
  );

  // result register
  ucer_stage #(
    .Width ($bits(ucer_out_t))
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid),
    .in_stall_o  (b_stall),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/ucer_stage.sv =====
// valid/stall register stage, full rate, used on the input and result side
// no package dependencies
module ucer_stage #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] out_data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  // hold only while the held transfer is stalled downstream
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/ucer_cfg_regs.sv =====
// descriptor length registers written over the configuration port
// depends on ucer_pkg
module ucer_cfg_regs
  import ucer_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output ucer_lens_t lens_o
);

  ucer_lens_t lens_q, lens_d;

  // register decode
  always_comb begin
    lens_d = lens_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_LEN:  lens_d.device_len    = cfg_data_i;
        CFG_CONFIG_LEN:  lens_d.config_len    = cfg_data_i;
        CFG_REPORT_LEN:  lens_d.report_len    = cfg_data_i;
        CFG_STRING0_LEN: lens_d.string_len[0] = cfg_data_i;
        CFG_STRING1_LEN: lens_d.string_len[1] = cfg_data_i;
        CFG_STRING2_LEN: lens_d.string_len[2] = cfg_data_i;
        CFG_STRING3_LEN: lens_d.string_len[3] = cfg_data_i;
        CFG_STRING4_LEN: lens_d.string_len[4] = cfg_data_i;
        default:         lens_d = lens_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lens_q <= LENS_RESET;
    end else begin
      lens_q <= lens_d;
    end
  end

  assign lens_o = lens_q;

endmodule

// ===== rtl/ucer_engine.sv =====
// request decode and endpoint 0 state, one event per enabled cycle
// depends on ucer_pkg
module ucer_engine
  import ucer_pkg::*;
#(
  parameter int unsigned Ep0PacketBytes = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  ucer_in_t   item_i,
  input  ucer_lens_t lens_i,
  output ucer_out_t  result_o
);

  localparam logic [15:0] PktBytes = 16'(Ep0PacketBytes);
  localparam logic [6:0]  PktTx    = 7'(Ep0PacketBytes);

  logic [7:0]  pending_q, pending_d;
  logic [15:0] remain_q, remain_d;
  logic [3:0]  src_sel_q, src_sel_d;
  logic [7:0]  offset_q, offset_d;
  logic        toggle_q, toggle_d;
  logic [6:0]  pend_addr_q, pend_addr_d;
  logic [6:0]  cur_addr_q, cur_addr_d;
  logic [7:0]  config_q, config_d;
  logic        stalled_q, stalled_d;

  logic [7:0]  vlo, desc_type;
  logic [3:0]  desc_src;
  logic [7:0]  desc_len;
  logic        desc_bad;
  logic [7:0]  desc_rem;
  logic [6:0]  desc_tx;
  logic [6:0]  in_tx;
  logic        reject;

  logic [1:0]  hs;
  logic [6:0]  tx;
  logic [3:0]  src;
  logic [7:0]  off;
  logic [1:0]  ep1;

  assign vlo       = item_i.request_value[7:0];
  assign desc_type = item_i.request_value[15:8];

  // descriptor source and length lookup
  always_comb begin
    desc_src = SRC_NONE;
    desc_len = 8'd0;
    desc_bad = 1'b0;
    unique case (desc_type)
      DESC_DEVICE: begin
        desc_src = SRC_DEVICE;
        desc_len = lens_i.device_len;
      end
      DESC_CONFIG: begin
        desc_src = SRC_CONFIG;
        desc_len = lens_i.config_len;
      end
      DESC_STRING: begin
        // unknown string index falls back to the language string
        if (vlo <= MAX_STRING_IDX) begin
          desc_src = SRC_STRING0 + {1'b0, vlo[2:0]};
          desc_len = lens_i.string_len[vlo[2:0]];
        end else begin
          desc_src = SRC_STRING0;
          desc_len = lens_i.string_len[0];
        end
      end
      DESC_REPORT: begin
        desc_src = SRC_REPORT;
        desc_len = lens_i.report_len;
        desc_bad = (vlo != 8'd0);
      end
      default: desc_bad = 1'b1;
    endcase
  end

  // clamp to wLength and descriptor length, then first chunk
  assign desc_rem = (item_i.request_length > {8'd0, desc_len}) ? desc_len
                                                                : item_i.request_length[7:0];
  assign desc_tx  = ({8'd0, desc_rem} >= PktBytes) ? PktTx : desc_rem[6:0];
  // next chunk of a descriptor in progress
  assign in_tx    = (remain_q >= PktBytes) ? PktTx : remain_q[6:0];

  // event handling
  always_comb begin
    pending_d   = pending_q;
    remain_d    = remain_q;
    src_sel_d   = src_sel_q;
    offset_d    = offset_q;
    toggle_d    = toggle_q;
    pend_addr_d = pend_addr_q;
    cur_addr_d  = cur_addr_q;
    config_d    = config_q;
    stalled_d   = stalled_q;
    hs          = HS_NAK_IN;
    tx          = 7'd0;
    src         = SRC_NONE;
    off         = 8'd0;
    ep1         = EP1_NONE;
    reject      = 1'b0;
    if (fire_i) begin
      unique case (item_i.func)
        FUNC_SETUP: begin
          toggle_d = 1'b1;
          if (!item_i.packet_ok) begin
            reject = 1'b1;
          end else begin
            remain_d  = item_i.request_length;
            pending_d = item_i.request_code;
            if (item_i.request_type[6:5] != 2'd0) begin
              reject = 1'b1;
            end else begin
              unique case (item_i.request_code)
                REQ_GET_DESCRIPTOR: begin
                  if (desc_bad) begin
                    reject = 1'b1;
                  end else begin
                    tx        = desc_tx;
                    src       = desc_src;
                    remain_d  = {8'd0, desc_rem} - {9'd0, desc_tx};
                    src_sel_d = desc_src;
                    offset_d  = {1'b0, desc_tx};
                  end
                end
                REQ_SET_ADDRESS: begin
                  remain_d    = {8'd0, vlo};
                  pend_addr_d = vlo[6:0];
                end
                REQ_GET_CONFIGURATION: begin
                  src = SRC_CONFIG_VALUE;
                  tx  = (item_i.request_length != 16'd0) ? 7'd1 : 7'd0;
                end
                REQ_SET_CONFIGURATION: config_d = vlo;
                REQ_GET_INTERFACE, REQ_SET_INTERFACE: begin
                  reject = 1'b0;
                end
                REQ_CLEAR_FEATURE: begin
                  if (item_i.request_type[4:0] == RECIP_ENDPOINT &&
                      item_i.request_index[7:0] == EP1_IN_ADDR) begin
                    ep1 = EP1_CLEAR;
                  end else begin
                    reject = 1'b1;
                  end
                end
                REQ_SET_FEATURE: begin
                  if (item_i.request_type[4:0] == RECIP_ENDPOINT &&
                      item_i.request_value == 16'd0 &&
                      item_i.request_index == {8'd0, EP1_IN_ADDR}) begin
                    ep1 = EP1_STALL;
                  end else begin
                    reject = 1'b1;
                  end
                end
                REQ_GET_STATUS: begin
                  src = SRC_ZERO_STATUS;
                  tx  = (item_i.request_length >= 16'd2) ? 7'd2
                                                         : item_i.request_length[6:0];
                end
                default: reject = 1'b1;
              endcase
            end
          end
          if (reject) begin
            pending_d = REQ_NONE;
            stalled_d = 1'b1;
            hs        = HS_STALL;
            tx        = 7'd0;
            src       = SRC_NONE;
            ep1       = EP1_NONE;
          end else begin
            stalled_d = 1'b0;
            hs        = HS_ACK;
          end
        end
        FUNC_IN_DONE: begin
          stalled_d = 1'b0;
          if (pending_q == REQ_GET_DESCRIPTOR) begin
            tx       = in_tx;
            src      = src_sel_q;
            off      = offset_q;
            remain_d = remain_q - {9'd0, in_tx};
            offset_d = offset_q + {1'b0, in_tx};
            toggle_d = ~toggle_q;
            hs       = HS_ACK;
          end else begin
            // status stage done, a new address takes effect here
            if (pending_q == REQ_SET_ADDRESS) begin
              cur_addr_d = pend_addr_q;
            end
            toggle_d = 1'b0;
            hs       = HS_NAK_IN;
          end
        end
        FUNC_OUT_DONE: begin
          hs = stalled_q ? HS_STALL : HS_NAK_IN;
        end
        FUNC_BUS_RESET: begin
          stalled_d  = 1'b0;
          toggle_d   = 1'b0;
          cur_addr_d = 7'd0;
          hs         = HS_NAK_IN;
          ep1        = EP1_CLEAR;
        end
        default: hs = HS_NAK_IN;
      endcase
    end
    // an empty packet names no source
    if (tx == 7'd0) begin
      src = SRC_NONE;
      off = 8'd0;
    end
  end

  // endpoint state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= REQ_NONE;
      remain_q    <= 16'd0;
      src_sel_q   <= SRC_NONE;
      offset_q    <= 8'd0;
      toggle_q    <= 1'b1;
      pend_addr_q <= 7'd0;
      cur_addr_q  <= 7'd0;
      config_q    <= 8'd0;
      stalled_q   <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      remain_q    <= remain_d;
      src_sel_q   <= src_sel_d;
      offset_q    <= offset_d;
      toggle_q    <= toggle_d;
      pend_addr_q <= pend_addr_d;
      cur_addr_q  <= cur_addr_d;
      config_q    <= config_d;
      stalled_q   <= stalled_d;
    end
  end

  // result fields show the state after this event
  always_comb begin
    result_o.handshake            = hs;
    result_o.tx_length            = tx;
    result_o.data_source          = src;
    result_o.data_offset          = off;
    result_o.data_toggle          = toggle_d;
    result_o.device_address       = cur_addr_d;
    result_o.ep1_action           = ep1;
    result_o.active_configuration = config_d;
  end

endmodule

// ===== rtl/ucer_checker.sv =====
// port-level checks for the control endpoint request handler, bound to the top
// depends on ucer_pkg and usb_control_endpoint_requests_defines.svh
`include "usb_control_endpoint_requests_defines.svh"

module ucer_checker
  import ucer_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ucer_out_t out_data_o
);

  // input side only backs up behind a stalled result
  `UCER_ASSERT(a_in_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a stalled result")

  // a stalled result transfer stays offered and unchanged
  `UCER_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "stalled result changed or dropped")

  // an empty packet names no source and no offset
  `UCER_ASSERT(a_empty_chunk, (out_valid_o && out_data_o.tx_length == 7'd0) |-> (out_data_o.data_source == SRC_NONE && out_data_o.data_offset == 8'd0), "empty packet with source or offset")

  // a stalled request sends nothing and leaves EP1 alone
  `UCER_ASSERT(a_stall_quiet, (out_valid_o && out_data_o.handshake == HS_STALL) |-> (out_data_o.tx_length == 7'd0 && out_data_o.ep1_action == EP1_NONE), "stall with data or ep1 action")

  // no result is offered while reset is applied
  `UCER_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind usb_control_endpoint_requests ucer_checker u_checker (.*);
